>>> src/stt_pkg.sv
// Shared types, character codes and helper functions of the source text tokenizer.
package stt_pkg;

  localparam int POS_BITS = 16;
  localparam int FIELD_BITS = 16;
  localparam int MAX_RESULTS = 3;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_PIPE = 8'h7C;

  typedef enum logic [3:0] {
    KIND_IDENT  = 4'd0,
    KIND_NUMBER = 4'd1,
    KIND_DOT    = 4'd2,
    KIND_PIPE   = 4'd3,
    KIND_EQ     = 4'd4,
    KIND_EQEQ   = 4'd5,
    KIND_ARROW  = 4'd6,
    KIND_PLUS   = 4'd7,
    KIND_MINUS  = 4'd8,
    KIND_ERROR  = 4'd9,
    KIND_EOF    = 4'd10
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_NUMDOT  = 3'd3,
    MODE_SLASH   = 3'd4,
    MODE_COMMENT = 3'd5,
    MODE_EQ      = 3'd6,
    MODE_DONE    = 3'd7
  } mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [3:0]            token_kind;
    logic                  is_lexeme_char;
    logic [7:0]            lexeme_char;
    logic [FIELD_BITS-1:0] token_line;
    logic [FIELD_BITS-1:0] token_column;
    logic [FIELD_BITS-1:0] token_length;
    logic                  last;
  } out_item_t;

  // All results caused by one request, slot 0 first.
  typedef struct packed {
    out_item_t [MAX_RESULTS-1:0] item;
    logic [1:0]                  count;
  } result_bundle_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  // Low field bits of a position counter, zero-extended when the counter is narrower.
  function automatic logic [FIELD_BITS-1:0] pos_field(input logic [POS_BITS-1:0] v);
    logic [POS_BITS+FIELD_BITS-1:0] w;
    w = {{FIELD_BITS{1'b0}}, v};
    return w[FIELD_BITS-1:0];
  endfunction

  function automatic out_item_t mk_item(input kind_t kind, input logic islex,
                                        input logic [7:0] ch,
                                        input logic [POS_BITS-1:0] ln,
                                        input logic [POS_BITS-1:0] col,
                                        input logic [POS_BITS-1:0] len);
    out_item_t r;
    r.token_kind = kind;
    r.is_lexeme_char = islex;
    r.lexeme_char = ch;
    r.token_line = pos_field(ln);
    r.token_column = pos_field(col);
    r.token_length = pos_field(len);
    r.last = 1'b0;
    return r;
  endfunction

endpackage

>>> src/stt_scan.sv
// Scanner state and the single-pass logic that turns one byte into its results.
module stt_scan (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  stt_pkg::in_item_t       item,
  output stt_pkg::result_bundle_t bundle
);

  stt_pkg::mode_t                 mode, mode_next;
  logic [stt_pkg::POS_BITS-1:0]   line_cnt, line_cnt_next;
  logic [stt_pkg::POS_BITS-1:0]   col_cnt, col_cnt_next;
  logic [stt_pkg::POS_BITS-1:0]   start_line, start_line_next;
  logic [stt_pkg::POS_BITS-1:0]   start_col, start_col_next;
  logic [stt_pkg::POS_BITS-1:0]   lex_cnt, lex_cnt_next;

  stt_pkg::out_item_t             res [0:stt_pkg::MAX_RESULTS-1];
  logic [1:0]                     n;
  logic                           do_idle;
  logic                           is_end;
  logic [7:0]                     c;
  logic [stt_pkg::POS_BITS-1:0]   dot_col;
  stt_pkg::kind_t                 word_kind;

  always_comb begin
    c = item.text_byte;
    is_end = item.end_of_text || (c == stt_pkg::CH_NUL);
    mode_next = mode;
    line_cnt_next = line_cnt;
    col_cnt_next = col_cnt;
    start_line_next = start_line;
    start_col_next = start_col;
    lex_cnt_next = lex_cnt;
    n = 2'd0;
    do_idle = 1'b0;
    for (int i = 0; i < stt_pkg::MAX_RESULTS; i++) begin
      res[i] = '0;
    end
    dot_col = (col_cnt == stt_pkg::POS_MAX) ? stt_pkg::POS_MAX : col_cnt - 1'b1;
    word_kind = (mode == stt_pkg::MODE_IDENT) ? stt_pkg::KIND_IDENT : stt_pkg::KIND_NUMBER;

    if (mode != stt_pkg::MODE_DONE) begin
      if (is_end) begin
        unique case (mode)
          stt_pkg::MODE_IDENT, stt_pkg::MODE_NUMBER: begin
            res[n] = stt_pkg::mk_item(word_kind, 1'b0, 8'd0, start_line, start_col, lex_cnt);
            n = n + 2'd1;
          end
          stt_pkg::MODE_NUMDOT: begin
            res[n] = stt_pkg::mk_item(stt_pkg::KIND_NUMBER, 1'b0, 8'd0, start_line,
                                      start_col, lex_cnt);
            n = n + 2'd1;
            res[n] = stt_pkg::mk_item(stt_pkg::KIND_DOT, 1'b0, 8'd0, line_cnt, dot_col, '0);
            n = n + 2'd1;
          end
          stt_pkg::MODE_SLASH: begin
            res[n] = stt_pkg::mk_item(stt_pkg::KIND_ERROR, 1'b0, 8'd0, start_line,
                                      start_col, '0);
            n = n + 2'd1;
          end
          stt_pkg::MODE_EQ: begin
            res[n] = stt_pkg::mk_item(stt_pkg::KIND_EQ, 1'b0, 8'd0, start_line, start_col, '0);
            n = n + 2'd1;
          end
          default: begin
          end
        endcase
        res[n] = stt_pkg::mk_item(stt_pkg::KIND_EOF, 1'b0, 8'd0, line_cnt, col_cnt, '0);
        n = n + 2'd1;
        mode_next = stt_pkg::MODE_DONE;
      end else begin
        unique case (mode)
          stt_pkg::MODE_IDENT: begin
            if (stt_pkg::is_letter(c)) begin
              lex_cnt_next = stt_pkg::sat_inc(lex_cnt);
              res[n] = stt_pkg::mk_item(stt_pkg::KIND_IDENT, 1'b1, c, start_line, start_col, '0);
              n = n + 2'd1;
            end else begin
              res[n] = stt_pkg::mk_item(stt_pkg::KIND_IDENT, 1'b0, 8'd0, start_line,
                                        start_col, lex_cnt);
              n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          stt_pkg::MODE_NUMBER: begin
            if (stt_pkg::is_digit(c)) begin
              lex_cnt_next = stt_pkg::sat_inc(lex_cnt);
              res[n] = stt_pkg::mk_item(stt_pkg::KIND_NUMBER, 1'b1, c, start_line,
                                        start_col, '0);
              n = n + 2'd1;
            end else if (c == stt_pkg::CH_DOT) begin
              mode_next = stt_pkg::MODE_NUMDOT;
            end else begin
              res[n] = stt_pkg::mk_item(stt_pkg::KIND_NUMBER, 1'b0, 8'd0, start_line,
                                        start_col, lex_cnt);
              n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          stt_pkg::MODE_NUMDOT: begin
            if (stt_pkg::is_digit(c)) begin
              lex_cnt_next = stt_pkg::sat_inc(stt_pkg::sat_inc(lex_cnt));
              res[n] = stt_pkg::mk_item(stt_pkg::KIND_NUMBER, 1'b1, stt_pkg::CH_DOT,
                                        start_line, start_col, '0);
              n = n + 2'd1;
              res[n] = stt_pkg::mk_item(stt_pkg::KIND_NUMBER, 1'b1, c, start_line,
                                        start_col, '0);
              n = n + 2'd1;
              mode_next = stt_pkg::MODE_NUMBER;
            end else begin
              // Dot not followed by a digit: close the number, then emit the dot.
              res[n] = stt_pkg::mk_item(stt_pkg::KIND_NUMBER, 1'b0, 8'd0, start_line,
                                        start_col, lex_cnt);
              n = n + 2'd1;
              res[n] = stt_pkg::mk_item(stt_pkg::KIND_DOT, 1'b0, 8'd0, line_cnt, dot_col, '0);
              n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          stt_pkg::MODE_SLASH: begin
            if (c == stt_pkg::CH_SLASH) begin
              mode_next = stt_pkg::MODE_COMMENT;
            end else begin
              res[n] = stt_pkg::mk_item(stt_pkg::KIND_ERROR, 1'b0, 8'd0, start_line,
                                        start_col, '0);
              n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          stt_pkg::MODE_COMMENT: begin
            if (c == stt_pkg::CH_NL) begin
              mode_next = stt_pkg::MODE_IDLE;
            end
          end
          stt_pkg::MODE_EQ: begin
            if (c == stt_pkg::CH_EQ) begin
              res[n] = stt_pkg::mk_item(stt_pkg::KIND_EQEQ, 1'b0, 8'd0, start_line,
                                        start_col, '0);
              n = n + 2'd1;
              mode_next = stt_pkg::MODE_IDLE;
            end else if (c == stt_pkg::CH_GT) begin
              res[n] = stt_pkg::mk_item(stt_pkg::KIND_ARROW, 1'b0, 8'd0, start_line,
                                        start_col, '0);
              n = n + 2'd1;
              mode_next = stt_pkg::MODE_IDLE;
            end else begin
              res[n] = stt_pkg::mk_item(stt_pkg::KIND_EQ, 1'b0, 8'd0, start_line,
                                        start_col, '0);
              n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          default: begin
            do_idle = 1'b1;
          end
        endcase

        // Rescan the byte from the idle mode.
        if (do_idle) begin
          mode_next = stt_pkg::MODE_IDLE;
          if (stt_pkg::is_letter(c) || stt_pkg::is_digit(c)) begin
            start_line_next = line_cnt;
            start_col_next = col_cnt;
            lex_cnt_next = {{(stt_pkg::POS_BITS-1){1'b0}}, 1'b1};
            mode_next = stt_pkg::is_letter(c) ? stt_pkg::MODE_IDENT : stt_pkg::MODE_NUMBER;
            res[n] = stt_pkg::mk_item(stt_pkg::is_letter(c) ? stt_pkg::KIND_IDENT
                                                            : stt_pkg::KIND_NUMBER,
                                      1'b1, c, line_cnt, col_cnt, '0);
            n = n + 2'd1;
          end else if (c == stt_pkg::CH_EQ || c == stt_pkg::CH_SLASH) begin
            start_line_next = line_cnt;
            start_col_next = col_cnt;
            mode_next = (c == stt_pkg::CH_EQ) ? stt_pkg::MODE_EQ : stt_pkg::MODE_SLASH;
          end else if (c == stt_pkg::CH_SPACE || c == stt_pkg::CH_TAB ||
                       c == stt_pkg::CH_CR || c == stt_pkg::CH_NL) begin
            // Whitespace: nothing to emit.
          end else begin
            unique case (c)
              stt_pkg::CH_DOT:   res[n] = stt_pkg::mk_item(stt_pkg::KIND_DOT, 1'b0, 8'd0,
                                                           line_cnt, col_cnt, '0);
              stt_pkg::CH_PIPE:  res[n] = stt_pkg::mk_item(stt_pkg::KIND_PIPE, 1'b0, 8'd0,
                                                           line_cnt, col_cnt, '0);
              stt_pkg::CH_PLUS:  res[n] = stt_pkg::mk_item(stt_pkg::KIND_PLUS, 1'b0, 8'd0,
                                                           line_cnt, col_cnt, '0);
              stt_pkg::CH_MINUS: res[n] = stt_pkg::mk_item(stt_pkg::KIND_MINUS, 1'b0, 8'd0,
                                                           line_cnt, col_cnt, '0);
              default:           res[n] = stt_pkg::mk_item(stt_pkg::KIND_ERROR, 1'b0, 8'd0,
                                                           line_cnt, col_cnt, '0);
            endcase
            n = n + 2'd1;
          end
        end

        if (c == stt_pkg::CH_NL) begin
          line_cnt_next = stt_pkg::sat_inc(line_cnt);
          col_cnt_next = '0;
        end else begin
          col_cnt_next = stt_pkg::sat_inc(col_cnt);
        end
      end
    end

    if (n != 2'd0) begin
      res[n - 2'd1].last = 1'b1;
    end

    for (int i = 0; i < stt_pkg::MAX_RESULTS; i++) begin
      bundle.item[i] = res[i];
    end
    bundle.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= stt_pkg::MODE_IDLE;
      line_cnt <= {{(stt_pkg::POS_BITS-1){1'b0}}, 1'b1};
      col_cnt <= '0;
      start_line <= '0;
      start_col <= '0;
      lex_cnt <= '0;
    end else if (accept) begin
      mode <= mode_next;
      line_cnt <= line_cnt_next;
      col_cnt <= col_cnt_next;
      start_line <= start_line_next;
      start_col <= start_col_next;
      lex_cnt <= lex_cnt_next;
    end
  end

endmodule

>>> src/source_text_tokenizer_top.sv
// Top level of the source text tokenizer: scanner plus result register with drain queue.
//
//   channel   direction  handshake              payload
//   src       in         src_valid/src_ready    src_item (stt_pkg::in_item_t)
//   tok       out        tok_valid/tok_ready    tok_item (stt_pkg::out_item_t)
//
// A request is scanned in the cycle it is accepted; its zero to three results land in a
// three-slot result register in the following cycle and drain one per cycle from slot 0
// while tok_ready is high. A new request is taken when the slots are empty or the last
// one leaves this cycle, so a stream of bytes with at most one result each flows at one
// byte per cycle while tok_ready holds; a byte with more results holds the source side while the slots drain.
// Reset (rst, synchronous) empties the slots and returns the scanner to line 1, column 0.
// A stall on tok holds the slots and, once they are not draining, src_ready.
module source_text_tokenizer_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_ready,
  input  stt_pkg::in_item_t  src_item,
  output logic               tok_valid,
  input  logic               tok_ready,
  output stt_pkg::out_item_t tok_item
);

  stt_pkg::result_bundle_t bundle;
  stt_pkg::out_item_t      slot [0:stt_pkg::MAX_RESULTS-1];
  logic [1:0]              cnt;
  logic                    accept;
  logic                    pop;

  // Scanner: state advances only on an accepted request.
  stt_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (src_item),
    .bundle (bundle)
  );

  assign tok_valid = (cnt != 2'd0);
  assign tok_item = slot[0];
  assign pop = tok_valid && tok_ready;
  // Take a request when the slots are free, or the final pending result leaves now.
  assign src_ready = (cnt == 2'd0) || (cnt == 2'd1 && tok_ready);
  assign accept = src_valid && src_ready;

  // Slot count: load a fresh bundle, or drop one result per pop.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (accept) begin
      cnt <= bundle.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Payload slots: load from the scanner, or advance toward slot 0 on a pop.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < stt_pkg::MAX_RESULTS; i++) begin
        slot[i] <= bundle.item[i];
      end
    end else if (pop) begin
      for (int i = 0; i < stt_pkg::MAX_RESULTS - 1; i++) begin
        slot[i] <= slot[i+1];
      end
    end
  end

endmodule

>>> bench/tb_source_text_tokenizer_top.sv
// Self-checking bench for the source text tokenizer: random and directed text.
module tb_source_text_tokenizer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int RANDOM_BYTES = 300;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_ZERO = 8'h30;

  // Token scoreboard: tracks scanner state, predicts the tokens each accepted byte
  // produces, and matches them in order against what leaves the block.
  class lexer_scoreboard;
    stt_pkg::mode_t scan;
    logic [stt_pkg::POS_BITS-1:0] line_no, col_no, tok_line, tok_col, word_len;
    stt_pkg::out_item_t fresh[$];
    stt_pkg::out_item_t tokens_due[$];
    int errors, bytes_taken, tokens_checked;
    int kind_hits[11];

    function new();
      scan = stt_pkg::MODE_IDLE;
      line_no = {{(stt_pkg::POS_BITS-1){1'b0}}, 1'b1};
      col_no = '0;
      tok_line = '0;
      tok_col = '0;
      word_len = '0;
      errors = 0;
      bytes_taken = 0;
      tokens_checked = 0;
      foreach (kind_hits[k]) kind_hits[k] = 0;
    endfunction

    function bit alpha(logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function bit numeral(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
    endfunction

    function logic [stt_pkg::POS_BITS-1:0] bump(logic [stt_pkg::POS_BITS-1:0] v);
      return (v == stt_pkg::POS_MAX) ? v : v + 1'b1;
    endfunction

    function void put(stt_pkg::kind_t k, logic lex, logic [7:0] ch,
                      logic [stt_pkg::POS_BITS-1:0] ln,
                      logic [stt_pkg::POS_BITS-1:0] col,
                      logic [stt_pkg::POS_BITS-1:0] len);
      stt_pkg::out_item_t t;
      if (fresh.size() >= stt_pkg::MAX_RESULTS) return;
      t.token_kind = k;
      t.is_lexeme_char = lex;
      t.lexeme_char = ch;
      t.token_line = ln;
      t.token_column = col;
      t.token_length = len;
      t.last = 1'b0;
      kind_hits[int'(k)]++;
      fresh.push_back(t);
    endfunction

    function void close_word();
      if (scan == stt_pkg::MODE_IDENT) begin
        put(stt_pkg::KIND_IDENT, 1'b0, 8'h00, tok_line, tok_col, word_len);
      end else begin
        put(stt_pkg::KIND_NUMBER, 1'b0, 8'h00, tok_line, tok_col, word_len);
      end
    endfunction

    // The held dot sits one column back, unless the column is pinned at its ceiling.
    function logic [stt_pkg::POS_BITS-1:0] dot_col();
      return (col_no == stt_pkg::POS_MAX) ? stt_pkg::POS_MAX : col_no - 1'b1;
    endfunction

    function void scan_fresh(logic [7:0] c, logic [stt_pkg::POS_BITS-1:0] ln,
                             logic [stt_pkg::POS_BITS-1:0] col);
      scan = stt_pkg::MODE_IDLE;
      if (c == stt_pkg::CH_SPACE || c == stt_pkg::CH_TAB || c == stt_pkg::CH_CR ||
          c == stt_pkg::CH_NL) return;
      if (alpha(c) || numeral(c)) begin
        tok_line = ln;
        tok_col = col;
        word_len = {{(stt_pkg::POS_BITS-1){1'b0}}, 1'b1};
        if (alpha(c)) begin
          scan = stt_pkg::MODE_IDENT;
          put(stt_pkg::KIND_IDENT, 1'b1, c, ln, col, '0);
        end else begin
          scan = stt_pkg::MODE_NUMBER;
          put(stt_pkg::KIND_NUMBER, 1'b1, c, ln, col, '0);
        end
        return;
      end
      case (c)
        stt_pkg::CH_DOT: put(stt_pkg::KIND_DOT, 1'b0, 8'h00, ln, col, '0);
        stt_pkg::CH_PIPE: put(stt_pkg::KIND_PIPE, 1'b0, 8'h00, ln, col, '0);
        stt_pkg::CH_PLUS: put(stt_pkg::KIND_PLUS, 1'b0, 8'h00, ln, col, '0);
        stt_pkg::CH_MINUS: put(stt_pkg::KIND_MINUS, 1'b0, 8'h00, ln, col, '0);
        stt_pkg::CH_EQ: begin
          tok_line = ln;
          tok_col = col;
          scan = stt_pkg::MODE_EQ;
        end
        stt_pkg::CH_SLASH: begin
          tok_line = ln;
          tok_col = col;
          scan = stt_pkg::MODE_SLASH;
        end
        default: put(stt_pkg::KIND_ERROR, 1'b0, 8'h00, ln, col, '0);
      endcase
    endfunction

    function void note_byte(stt_pkg::in_item_t req);
      logic [7:0] c;
      bit stop;
      logic [stt_pkg::POS_BITS-1:0] ln, col;
      stt_pkg::out_item_t t;
      c = req.text_byte;
      stop = req.end_of_text || (c == stt_pkg::CH_NUL);
      ln = line_no;
      col = col_no;
      if (scan == stt_pkg::MODE_DONE) return;
      bytes_taken++;
      fresh.delete();
      if (stop) begin
        case (scan)
          stt_pkg::MODE_IDENT, stt_pkg::MODE_NUMBER: close_word();
          stt_pkg::MODE_NUMDOT: begin
            scan = stt_pkg::MODE_NUMBER;
            close_word();
            put(stt_pkg::KIND_DOT, 1'b0, 8'h00, ln, dot_col(), '0);
          end
          stt_pkg::MODE_SLASH: put(stt_pkg::KIND_ERROR, 1'b0, 8'h00, tok_line, tok_col, '0);
          stt_pkg::MODE_EQ: put(stt_pkg::KIND_EQ, 1'b0, 8'h00, tok_line, tok_col, '0);
          default: ;
        endcase
        put(stt_pkg::KIND_EOF, 1'b0, 8'h00, ln, col, '0);
        scan = stt_pkg::MODE_DONE;
      end else begin
        case (scan)
          stt_pkg::MODE_IDENT: begin
            if (alpha(c)) begin
              word_len = bump(word_len);
              put(stt_pkg::KIND_IDENT, 1'b1, c, tok_line, tok_col, '0);
            end else begin
              close_word();
              scan_fresh(c, ln, col);
            end
          end
          stt_pkg::MODE_NUMBER: begin
            if (numeral(c)) begin
              word_len = bump(word_len);
              put(stt_pkg::KIND_NUMBER, 1'b1, c, tok_line, tok_col, '0);
            end else if (c == stt_pkg::CH_DOT) begin
              scan = stt_pkg::MODE_NUMDOT;
            end else begin
              close_word();
              scan_fresh(c, ln, col);
            end
          end
          stt_pkg::MODE_NUMDOT: begin
            scan = stt_pkg::MODE_NUMBER;
            if (numeral(c)) begin
              word_len = bump(bump(word_len));
              put(stt_pkg::KIND_NUMBER, 1'b1, stt_pkg::CH_DOT, tok_line, tok_col, '0);
              put(stt_pkg::KIND_NUMBER, 1'b1, c, tok_line, tok_col, '0);
            end else begin
              close_word();
              put(stt_pkg::KIND_DOT, 1'b0, 8'h00, ln, dot_col(), '0);
              scan_fresh(c, ln, col);
            end
          end
          stt_pkg::MODE_SLASH: begin
            if (c == stt_pkg::CH_SLASH) begin
              scan = stt_pkg::MODE_COMMENT;
            end else begin
              put(stt_pkg::KIND_ERROR, 1'b0, 8'h00, tok_line, tok_col, '0);
              scan_fresh(c, ln, col);
            end
          end
          stt_pkg::MODE_COMMENT: begin
            if (c == stt_pkg::CH_NL) scan = stt_pkg::MODE_IDLE;
          end
          stt_pkg::MODE_EQ: begin
            if (c == stt_pkg::CH_EQ) begin
              put(stt_pkg::KIND_EQEQ, 1'b0, 8'h00, tok_line, tok_col, '0);
              scan = stt_pkg::MODE_IDLE;
            end else if (c == stt_pkg::CH_GT) begin
              put(stt_pkg::KIND_ARROW, 1'b0, 8'h00, tok_line, tok_col, '0);
              scan = stt_pkg::MODE_IDLE;
            end else begin
              put(stt_pkg::KIND_EQ, 1'b0, 8'h00, tok_line, tok_col, '0);
              scan_fresh(c, ln, col);
            end
          end
          default: scan_fresh(c, ln, col);
        endcase
        if (c == stt_pkg::CH_NL) begin
          line_no = bump(line_no);
          col_no = '0;
        end else begin
          col_no = bump(col_no);
        end
      end
      if (fresh.size() > 0) begin
        t = fresh.pop_back();
        t.last = 1'b1;
        fresh.push_back(t);
      end
      foreach (fresh[i]) tokens_due.push_back(fresh[i]);
    endfunction

    function bit field_bad(string name, logic [15:0] want, logic [15:0] got);
      if (got === want) return 1'b0;
      $display("%0t ns: token %0d field %s expected %h actual %h",
               $time, tokens_checked, name, want, got);
      return 1'b1;
    endfunction

    function void check_token(stt_pkg::out_item_t got);
      stt_pkg::out_item_t want;
      bit bad;
      tokens_checked++;
      if (tokens_due.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected token expected none actual %h", $time, got);
        return;
      end
      want = tokens_due.pop_front();
      bad = field_bad("token_kind", 16'(want.token_kind), 16'(got.token_kind));
      bad |= field_bad("is_lexeme_char", 16'(want.is_lexeme_char), 16'(got.is_lexeme_char));
      bad |= field_bad("lexeme_char", 16'(want.lexeme_char), 16'(got.lexeme_char));
      bad |= field_bad("token_line", want.token_line, got.token_line);
      bad |= field_bad("token_column", want.token_column, got.token_column);
      bad |= field_bad("token_length", want.token_length, got.token_length);
      bad |= field_bad("last", 16'(want.last), 16'(got.last));
      if (bad) errors++;
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               src_valid;
  logic               src_ready;
  stt_pkg::in_item_t  src_item;
  logic               tok_valid;
  logic               tok_ready;
  stt_pkg::out_item_t tok_item;

  lexer_scoreboard sb;
  bit gaps_on;
  int ready_hold;
  int sent_count;

  source_text_tokenizer_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_item  (src_item),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok_item  (tok_item)
  );

  always #4 clk = ~clk;

  // Mostly back to back, sometimes a short hiccup, now and then a long pause.
  function automatic int pause_len();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] random_letter();
    if ($urandom_range(0, 1) == 1) return CH_LOW_A + 8'($urandom_range(0, 25));
    return CH_UP_A + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] random_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Receiver: stall tok_ready in random bursts while gaps are enabled.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      tok_ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 99) < 25) begin
      ready_hold <= pause_len();
      tok_ready <= 1'b0;
    end else begin
      tok_ready <= 1'b1;
    end
  end

  // Observe both channels on the same edge: retire tokens, then predict from the
  // request taken here (its tokens cannot show up before the next edge).
  always @(posedge clk) begin
    if (!rst) begin
      if (tok_valid && tok_ready) sb.check_token(tok_item);
      if (src_valid && src_ready) sb.note_byte(src_item);
    end
  end

  // Offer one byte and hold it until the block takes it. Called on a rising edge.
  task automatic send(input logic [7:0] b, input logic eot);
    stt_pkg::in_item_t req;
    int gap;
    req.text_byte = b;
    req.end_of_text = eot;
    gap = pause_len();
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_item <= req;
    do @(posedge clk); while (!src_ready);
    sent_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send(s[i], 1'b0);
  endtask

  // Drop valid and hold off until every predicted token has drained.
  task automatic drain_tokens();
    src_valid <= 1'b0;
    do @(posedge clk); while (sb.tokens_due.size() != 0);
  endtask

  // One random lexical unit; mostly well-formed tokens, with some noise mixed in.
  task automatic random_token();
    int pick;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6))
        send(random_letter(), 1'b0);
    end else if (pick < 40) begin
      repeat ($urandom_range(1, 4)) send(random_digit(), 1'b0);
      if ($urandom_range(0, 2) == 0) begin
        send(stt_pkg::CH_DOT, 1'b0);
        repeat ($urandom_range(1, 3)) send(random_digit(), 1'b0);
      end
    end else if (pick < 46) begin
      // trailing dot: whatever comes next decides whether it joins the number
      repeat ($urandom_range(1, 3)) send(random_digit(), 1'b0);
      send(stt_pkg::CH_DOT, 1'b0);
    end else if (pick < 60) begin
      case ($urandom_range(0, 4))
        0: send(stt_pkg::CH_DOT, 1'b0);
        1: send(stt_pkg::CH_PIPE, 1'b0);
        2: send(stt_pkg::CH_PLUS, 1'b0);
        3: send(stt_pkg::CH_MINUS, 1'b0);
        default: send(stt_pkg::CH_EQ, 1'b0);
      endcase
    end else if (pick < 66) begin
      send(stt_pkg::CH_EQ, 1'b0);
      send(($urandom_range(0, 1) == 1) ? stt_pkg::CH_EQ : stt_pkg::CH_GT, 1'b0);
    end else if (pick < 72) begin
      send(stt_pkg::CH_SLASH, 1'b0);
    end else if (pick < 78) begin
      // line comment with arbitrary bytes, closed by a newline
      send(stt_pkg::CH_SLASH, 1'b0);
      send(stt_pkg::CH_SLASH, 1'b0);
      repeat ($urandom_range(0, 8)) begin
        b = 8'($urandom_range(1, 255));
        if (b == stt_pkg::CH_NL) b = stt_pkg::CH_SPACE;
        send(b, 1'b0);
      end
      send(stt_pkg::CH_NL, 1'b0);
    end else if (pick < 92) begin
      case ($urandom_range(0, 3))
        0: send(stt_pkg::CH_SPACE, 1'b0);
        1: send(stt_pkg::CH_TAB, 1'b0);
        2: send(stt_pkg::CH_CR, 1'b0);
        default: send(stt_pkg::CH_NL, 1'b0);
      endcase
    end else begin
      send(8'($urandom_range(1, 255)), 1'b0);
    end
  endtask

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int start, kinds;
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    src_valid = 1'b0;
    src_item = '0;
    tok_ready = 1'b0;
    gaps_on = 1'b0;
    ready_hold = 0;
    sent_count = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: every operator, words split by the byte that ends them, a fractional
    // number, a number with a stray dot, stray '>', a lone slash, a comment, whitespace.
    send_text("aZ09 1.5 3.+|-==>=>=x/y//q\n\t\r");
    send(8'hFF, 1'b0);

    // Random text in chunks, toggling idling so some stretches run flat out.
    start = sent_count;
    for (int t = 0; sent_count - start < RANDOM_BYTES; t++) begin
      if (t % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if (t == 120) drain_tokens();
      random_token();
    end
    drain_tokens();

    // A little more random text, then end text right after a number with a
    // pending dot, and push a few bytes that must be ignored.
    gaps_on = 1'b1;
    repeat (20) random_token();
    send_text(" 4.");
    send(8'($urandom_range(1, 255)), 1'b1);
    send(stt_pkg::CH_NUL, 1'b0);
    send(8'($urandom_range(1, 255)), 1'b1);
    send(CH_LOW_A, 1'b0);
    drain_tokens();
    repeat (20) @(posedge clk);

    kinds = 0;
    foreach (sb.kind_hits[k]) if (sb.kind_hits[k] > 0) kinds++;
    $display("Run: %0d bytes scanned, %0d tokens checked, %0d of 11 token kinds produced.",
             sb.bytes_taken, sb.tokens_checked, kinds);
    $display("Included stalls on both sides, comments, stray bytes and bytes after end of text.");
    if (sb.errors == 0 && sb.tokens_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/stt_pkg.sv
src/stt_scan.sv
src/source_text_tokenizer_top.sv
bench/tb_source_text_tokenizer_top.sv
